// ===== rtl/knap_pkg.sv =====
package knap_pkg;

  localparam int DEF_MAX_CAPACITY = 1023;
  localparam int DEF_TOTAL_WIDTH  = 24;

  localparam int CAP_W    = 10;
  localparam int WEIGHT_W = 10;
  localparam int VALUE_W  = 16;
  localparam int OUT_W    = 24;

  // one table access per cycle, issued by the sequencer
  typedef struct packed {
    logic read;    // read entry at addr_a (and addr_b)
    logic update;  // with read: write max(cur, alt + value) back in the following cycle
    logic clear;   // zero entry at addr_a
  } knap_op_t;

endpackage

// ===== rtl/knap_table.sv =====
module knap_table import knap_pkg::*; #(
  parameter int MAX_CAPACITY = DEF_MAX_CAPACITY,
  parameter int TOTAL_WIDTH  = DEF_TOTAL_WIDTH,
  localparam int DEPTH  = MAX_CAPACITY + 1,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  knap_op_t               op,
  input  logic [ADDR_W-1:0]      addr_a,
  input  logic [ADDR_W-1:0]      addr_b,
  input  logic [VALUE_W-1:0]     item_value,
  output logic [TOTAL_WIDTH-1:0] rd_data
);

  localparam int SUM_W = ((TOTAL_WIDTH > VALUE_W) ? TOTAL_WIDTH : VALUE_W) + 1;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

  logic [TOTAL_WIDTH-1:0] mem [DEPTH];
  logic [TOTAL_WIDTH-1:0] cur_q;
  logic [TOTAL_WIDTH-1:0] alt_q;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   upd_q;
  logic [SUM_W-1:0]       sum;
  logic [TOTAL_WIDTH-1:0] cand;
  logic [TOTAL_WIDTH-1:0] new_total;

  always_ff @(posedge clk) begin
    if (op.read) begin
      cur_q   <= mem[addr_a];
      alt_q   <= mem[addr_b];
      wr_addr <= addr_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_q <= 1'b0;
    end else begin
      upd_q <= op.read && op.update;
    end
  end

  // saturating add and max, one entry per cycle
  always_comb begin
    sum       = SUM_W'(alt_q) + SUM_W'(item_value);
    cand      = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_WIDTH'(sum);
    new_total = (cand > cur_q) ? cand : cur_q;
  end

  always_ff @(posedge clk) begin
    if (op.clear) begin
      mem[addr_a] <= '0;
    end else if (upd_q) begin
      mem[wr_addr] <= new_total;
    end
  end

  assign rd_data = cur_q;

endmodule

// ===== rtl/zero_one_knapsack_dp.sv =====
// 0/1 knapsack solver, one-dimensional table of best totals.
// Configuration: write capacity with cfg_we; only while the block is idle.
// Input channel (in_valid/in_ready): one object per request (weight, value,
// last_item). Output channel (out_valid/out_ready): best_value, one result
// per request that carries last_item.
// Walk: an object with weight <= capacity occupies the block for one table
// read-modify-write per cycle through the shared add/max unit, from entry
// capacity down to entry weight, plus the write-back drain, and in_ready is
// low meanwhile; heavier objects pass only the drain step. A last object
// then reads the result, waits for the output register, and a clearing
// pass over all MAX_CAPACITY+1 entries (1024 by default) zeroes the table
// before the next request is taken.
// Reset: capacity goes to zero and the same clearing pass runs; in_ready
// stays low until the pass has zeroed every entry.
// Stall: the result sits in an output register; the block keeps taking
// objects of the next problem while it waits, and only a later result
// waits for the register to empty.
// Capacities above MAX_CAPACITY are clamped; totals saturate.
module zero_one_knapsack_dp import knap_pkg::*; #(
  parameter int MAX_CAPACITY = DEF_MAX_CAPACITY,
  parameter int TOTAL_WIDTH  = DEF_TOTAL_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    capacity,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [WEIGHT_W-1:0] item_weight,
  input  logic [VALUE_W-1:0]  item_value,
  input  logic                last_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_W-1:0]    best_value
);

  localparam int ADDR_W = $clog2(MAX_CAPACITY + 1);
  localparam int XW     = (ADDR_W > CAP_W) ? ADDR_W : CAP_W;
  localparam int RW     = (TOTAL_WIDTH > OUT_W) ? TOTAL_WIDTH : OUT_W;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_UPDATE   = 3'd2;
  localparam logic [2:0] ST_DRAIN    = 3'd3;
  localparam logic [2:0] ST_RES_RD   = 3'd4;
  localparam logic [2:0] ST_RES_WAIT = 3'd5;

  logic [2:0]             state, state_next;
  logic [CAP_W-1:0]       cap_reg;
  logic [ADDR_W-1:0]      s, s_next;
  logic [ADDR_W-1:0]      cap_q;
  logic [ADDR_W-1:0]      weight_q;
  logic [VALUE_W-1:0]     value_q;
  logic                   last_q;
  logic [XW-1:0]          cap_x;
  logic [XW-1:0]          eff_cap;
  logic                   fits;
  logic                   in_fire;
  logic                   out_load;
  knap_op_t               op;
  logic [ADDR_W-1:0]      addr_a;
  logic [ADDR_W-1:0]      addr_b;
  logic [TOTAL_WIDTH-1:0] rd_data;
  logic [RW-1:0]          rd_ext;
  logic [OUT_W-1:0]       res_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= '0;
    end else if (cfg_we) begin
      cap_reg <= capacity;
    end
  end

  always_comb begin
    cap_x   = XW'(cap_reg);
    eff_cap = (cap_x > XW'(MAX_CAPACITY)) ? XW'(MAX_CAPACITY) : cap_x;
    fits    = XW'(item_weight) <= eff_cap;
  end

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == ST_RES_WAIT) && (!out_valid || out_ready);

  // object fields held for the whole walk
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cap_q    <= ADDR_W'(eff_cap);
      weight_q <= ADDR_W'(item_weight);
      value_q  <= item_value;
      last_q   <= last_item;
    end
  end

  always_comb begin
    state_next = state;
    s_next     = s;
    op         = '0;
    addr_a     = s;
    addr_b     = s - weight_q;
    case (state)
      ST_CLEAR: begin
        op.clear = 1'b1;
        s_next   = s + 1'b1;
        if (s == ADDR_W'(MAX_CAPACITY)) begin
          s_next     = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          s_next     = ADDR_W'(eff_cap);
          state_next = fits ? ST_UPDATE : ST_DRAIN;
        end
      end
      ST_UPDATE: begin
        op.read   = 1'b1;
        op.update = 1'b1;
        s_next    = s - 1'b1;
        if (s == weight_q) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last write-back of the walk lands here
        state_next = last_q ? ST_RES_RD : ST_IDLE;
      end
      ST_RES_RD: begin
        op.read    = 1'b1;
        addr_a     = cap_q;
        addr_b     = cap_q;
        state_next = ST_RES_WAIT;
      end
      ST_RES_WAIT: begin
        if (out_load) begin
          s_next     = '0;
          state_next = ST_CLEAR;
        end
      end
      default: begin
        s_next     = '0;
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      s     <= '0;
    end else begin
      state <= state_next;
      s     <= s_next;
    end
  end

  knap_table #(
    .MAX_CAPACITY (MAX_CAPACITY),
    .TOTAL_WIDTH  (TOTAL_WIDTH)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .addr_a     (addr_a),
    .addr_b     (addr_b),
    .item_value (value_q),
    .rd_data    (rd_data)
  );

  always_comb begin
    rd_ext  = RW'(rd_data);
    res_sat = (rd_ext > RW'(OUT_MAX)) ? OUT_MAX : OUT_W'(rd_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      best_value <= res_sat;
    end
  end

`ifndef SYNTHESIS
  a_walk_above_weight: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> s >= weight_q)
    else $error("table walk went below the object weight");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an accepted request");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_RES_WAIT && out_valid && !out_ready |=> state == ST_RES_WAIT)
    else $error("result dropped while output register was full");

  a_out_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RES_WAIT)
    else $error("output raised outside the result step");
`endif

endmodule

// ===== dv/zero_one_knapsack_dp_tb.sv =====
`timescale 1ns / 1ps

module zero_one_knapsack_dp_tb;
  import knap_pkg::*;

  localparam int TABLE_DEPTH = DEF_MAX_CAPACITY + 1;
  localparam longint TOTAL_MAX = (64'd1 << DEF_TOTAL_WIDTH) - 1;
  localparam longint BEST_MAX = (64'd1 << OUT_W) - 1;
  localparam int ITEM_TARGET = 580;
  localparam int SAT_ITEMS = 280;
  // longest object walk plus result read and clearing pass, with margin
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CAP_W-1:0]    capacity;
  logic                in_valid;
  logic                in_ready;
  logic [WEIGHT_W-1:0] item_weight;
  logic [VALUE_W-1:0]  item_value;
  logic                last_item;
  logic                out_valid;
  logic                out_ready;
  logic [OUT_W-1:0]    best_value;

  bit tx_steady;
  bit rx_steady;
  int objs_sent;

  class knap_scoreboard;
    longint       best_tbl [TABLE_DEPTH];
    int           cur_cap;
    logic [OUT_W-1:0] pending_best [$];
    int           errors;

    function new();
      foreach (best_tbl[s]) best_tbl[s] = 0;
      cur_cap = 0;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      cur_cap = (c > DEF_MAX_CAPACITY) ? DEF_MAX_CAPACITY : int'(c);
    endfunction

    // walk capacities top-down so each object is taken at most once
    function void note_object(logic [WEIGHT_W-1:0] w, logic [VALUE_W-1:0] v, logic l);
      int     wi;
      longint cand;
      longint best;
      wi = int'(w);
      if (wi <= cur_cap) begin
        for (int s = cur_cap; s >= wi; s--) begin
          cand = best_tbl[s - wi] + longint'(v);
          if (cand > TOTAL_MAX) cand = TOTAL_MAX;
          if (cand > best_tbl[s]) best_tbl[s] = cand;
        end
      end
      if (l) begin
        best = best_tbl[cur_cap];
        if (best > BEST_MAX) best = BEST_MAX;
        pending_best = {pending_best, best[OUT_W-1:0]};
        foreach (best_tbl[s]) best_tbl[s] = 0;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] exp_best;
      if (pending_best.size() == 0) begin
        $error("best_value: no result expected, actual %0d", got);
        errors++;
      end else begin
        exp_best = pending_best.pop_front();
        if (got !== exp_best) begin
          $error("best_value mismatch: expected %0d, actual %0d", exp_best, got);
          errors++;
        end
      end
    endfunction

    function int leftover_check();
      if (pending_best.size() != 0) begin
        $error("best_value: %0d results never arrived", pending_best.size());
        errors += pending_best.size();
      end
      return errors;
    endfunction
  endclass

  knap_scoreboard sb = new();

  zero_one_knapsack_dp i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .capacity    (capacity),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .item_weight (item_weight),
    .item_value  (item_value),
    .last_item   (last_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .best_value  (best_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL zero_one_knapsack_dp");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(best_value);
  end

  // result side: random stall before each result unless rx_steady is set
  initial begin
    int gap;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_obj(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
                          input logic l);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    item_weight <= w;
    item_value  <= v;
    last_item   <= l;
    do @(posedge clk); while (!in_ready);
    sb.note_object(w, v, l);
    objs_sent++;
  endtask

  // stop sending, let every result arrive and any object walk finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_best.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    settle();
    cfg_we   <= 1'b1;
    capacity <= c;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_capacity(c);
  endtask

  initial begin
    int cap;
    int n;
    int wmax;
    bit close;
    logic [WEIGHT_W-1:0] w;
    logic [VALUE_W-1:0]  v;
    logic l;

    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    capacity    <= '0;
    in_valid    <= 1'b0;
    item_weight <= '0;
    item_value  <= '0;
    last_item   <= 1'b0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    objs_sent   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // zero capacity: zero-weight objects still count, heavier ones do not
    write_capacity(10'd0);
    send_obj(10'd0, 16'd5, 1'b0);
    send_obj(10'd0, 16'hFFFF, 1'b0);
    send_obj(10'd1, 16'd100, 1'b1);
    send_obj(10'd0, 16'd0, 1'b1);

    write_capacity(10'd1023);
    send_obj(10'd1023, 16'hFFFF, 1'b0);
    send_obj(10'd0, 16'd7, 1'b0);
    send_obj(10'd512, 16'd300, 1'b0);
    send_obj(10'd511, 16'd200, 1'b1);

    // problem left open across a capacity change
    write_capacity(10'd10);
    send_obj(10'd3, 16'd40, 1'b0);
    send_obj(10'd4, 16'd50, 1'b0);
    send_obj(10'd5, 16'd70, 1'b0);
    send_obj(10'd11, 16'd9999, 1'b0);
    send_obj(10'd10, 16'd100, 1'b0);
    write_capacity(10'd5);
    send_obj(10'd2, 16'd30, 1'b0);
    send_obj(10'd0, 16'd1, 1'b1);

    write_capacity(10'd1);
    send_obj(10'd1, 16'hAAAA, 1'b0);
    send_obj(10'd1, 16'h5555, 1'b1);

    write_capacity(10'h2AA);
    send_obj(10'h155, 16'h1234, 1'b0);
    send_obj(10'h2AA, 16'hFFFF, 1'b1);

    // long problem of mostly weightless, valuable objects: totals saturate
    write_capacity(10'd3);
    tx_steady = ($urandom_range(0, 1) == 0);
    for (int i = 0; i < SAT_ITEMS; i++) begin
      w = (i % 16 == 15) ? WEIGHT_W'($urandom_range(1, 3)) : '0;
      v = VALUE_W'($urandom_range(16'hFF00, 16'hFFFF));
      send_obj(w, v, i == SAT_ITEMS - 1);
    end

    while (objs_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 15))
        0:       cap = DEF_MAX_CAPACITY;
        1, 2:    cap = $urandom_range(256, 1023);
        3, 4:    cap = 0;
        default: cap = $urandom_range(1, 48);
      endcase
      write_capacity(CAP_W'(cap));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      n = (cap > 255) ? $urandom_range(1, 3) : $urandom_range(1, 14);
      close = ($urandom_range(0, 3) != 0);
      wmax = (cap + 2 > 1023) ? 1023 : cap + 2;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 7))
          0:       w = WEIGHT_W'($urandom_range(0, 1023));
          1:       w = '0;
          default: w = WEIGHT_W'($urandom_range(0, wmax));
        endcase
        case ($urandom_range(0, 7))
          0:       v = '0;
          1:       v = '1;
          default: v = VALUE_W'($urandom);
        endcase
        l = (i == n - 1) ? close : ($urandom_range(0, 4) == 0);
        send_obj(w, v, l);
      end
    end

    settle();
    if (sb.leftover_check() == 0) begin
      $display("PASS zero_one_knapsack_dp");
    end else begin
      $display("FAIL zero_one_knapsack_dp");
    end
    $finish;
  end

endmodule
